// ===== hw/rtl/dq_pkg.sv =====
// shared types and constants for the double-ended queue
`default_nettype none

package dq_pkg;

    localparam int DQ_DEPTH  = 16;
    localparam int DQ_DATA_W = 32;
    localparam int DQ_CNT_W  = 5;

    // operation codes
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } dq_op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } dq_status_t;

    // operation beat
    typedef struct packed {
        dq_op_t                       opcode;
        logic signed [DQ_DATA_W-1:0]  push_value;
    } dq_in_t;

    // result beat
    typedef struct packed {
        logic signed [DQ_DATA_W-1:0]  popped_value;
        dq_status_t                   status;
        logic [DQ_CNT_W-1:0]          item_count;
    } dq_out_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                  push_front;
        logic                  push_back;
        logic                  pop_front;
        logic                  pop_back;
        logic [DQ_DATA_W-1:0]  value;
    } dq_cmd_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                  occ;
        logic [DQ_DATA_W-1:0]  data;
        logic                  gflag;
        logic [DQ_DATA_W-1:0]  gword;
    } dq_link_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dq_cell.sv =====
// one storage cell of the queue row, with its gather stage for back pops
`default_nettype none

module dq_cell
    import dq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dq_cmd_t  cmd,
    input  wire dq_link_t left,
    input  wire dq_link_t right,
    output dq_link_t      link
);

    logic                  occ_reg, occ_next;
    logic [DQ_DATA_W-1:0]  data_reg, data_next;
    logic                  gflag_reg, gflag_next;
    logic [DQ_DATA_W-1:0]  gword_reg, gword_next;
    logic                  is_tail;

    assign is_tail = occ_reg && !right.occ;

    // storage: front push/pop shift right/left; back push/pop at tail
    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (cmd.push_front)
        begin
            occ_next  = left.occ;
            data_next = left.data;
        end
        else if (cmd.push_back)
        begin
            if (!occ_reg && left.occ)
            begin
                occ_next  = 1'b1;
                data_next = cmd.value;
            end
        end
        else if (cmd.pop_front)
        begin
            occ_next  = right.occ;
            data_next = right.data;
        end
        else if (cmd.pop_back)
        begin
            if (is_tail)
            begin
                occ_next = 1'b0;
            end
        end
    end

    // gather: tail word is captured, then walks toward the head cell
    always_comb
    begin
        if (cmd.pop_back)
        begin
            gflag_next = is_tail;
            gword_next = data_reg;
        end
        else
        begin
            gflag_next = right.gflag;
            gword_next = right.gword;
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            gflag_reg <= 1'b0;
        end
        else
        begin
            occ_reg   <= occ_next;
            gflag_reg <= gflag_next;
        end
    end

    // payload flops
    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        gword_reg <= gword_next;
    end

    assign link = '{occ: occ_reg, data: data_reg, gflag: gflag_reg, gword: gword_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// double-ended queue top level: row of cells, count and result register
//
//  channel  | valid     | stall     | beat
//  ---------+-----------+-----------+---------------------------
//  op       | op_valid  | op_stall  | op_beat  (dq_in_t)
//  res      | res_valid | res_stall | res_beat (dq_out_t)
//
// pushes, front pops and rejected ops: one beat per cycle while op_stall is low,
// result in the next cycle; back pop: the tail word walks to the head cell with
// op_stall high, and the result is registered once it reaches the head cell
// op_stall is high while a back pop walks and while a result waits on res_stall
// reset clears the count and all cell occupancy; cell data is not cleared
`default_nettype none

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    op_valid,
    output logic         op_stall,
    input  wire dq_in_t  op_beat,
    output logic         res_valid,
    input  wire logic    res_stall,
    output dq_out_t      res_beat
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              op_accept;
    logic              full;
    logic              empty;
    dq_cmd_t           cmd;
    dq_link_t          link [DEPTH];
    logic [DEPTH-1:0]  occ_vec;
    logic [DEPTH-1:0]  gflag_vec;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              busy_reg, busy_next;
    logic              res_valid_reg, res_valid_next;
    dq_out_t           res_reg, res_next;
    logic [CNT_W+DQ_CNT_W-1:0] cnt_ext;

    assign op_stall  = busy_reg || (res_valid_reg && res_stall);
    assign op_accept = op_valid && !op_stall;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    // command decode
    always_comb
    begin
        cmd            = '0;
        cmd.value      = op_beat.push_value;
        cmd.push_front = op_accept && (op_beat.opcode == OP_PUSH_FRONT) && !full;
        cmd.push_back  = op_accept && (op_beat.opcode == OP_PUSH_BACK)  && !full;
        cmd.pop_front  = op_accept && (op_beat.opcode == OP_POP_FRONT)  && !empty;
        cmd.pop_back   = op_accept && (op_beat.opcode == OP_POP_BACK)   && !empty;
    end

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dq_link_t left_in;
        dq_link_t right_in;

        if (i == 0)
        begin : g_head
            assign left_in = '{occ: 1'b1, data: op_beat.push_value, gflag: 1'b0, gword: '0};
        end
        else
        begin : g_body
            assign left_in = link[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid
            assign right_in = link[i+1];
        end

        dq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_in),
            .right (right_in),
            .link  (link[i])
        );

        assign occ_vec[i]   = link[i].occ;
        assign gflag_vec[i] = link[i].gflag;
    end

    // count and back-pop walk
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_front || cmd.push_back)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop_front || cmd.pop_back)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        busy_next = busy_reg;
        if (cmd.pop_back)
        begin
            busy_next = 1'b1;
        end
        else if (link[0].gflag)
        begin
            busy_next = 1'b0;
        end
    end

    assign cnt_ext = {{DQ_CNT_W{1'b0}}, count_next};

    // result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (op_accept && !cmd.pop_back)
        begin
            res_valid_next        = 1'b1;
            res_next.popped_value = '0;
            res_next.status       = ST_DONE;
            res_next.item_count   = cnt_ext[DQ_CNT_W-1:0];
            if (cmd.pop_front)
            begin
                res_next.popped_value = link[0].data;
            end
            else if (op_beat.opcode == OP_POP_FRONT || op_beat.opcode == OP_POP_BACK)
            begin
                res_next.status = ST_EMPTY;
            end
            else if (full)
            begin
                res_next.status = ST_FULL;
            end
        end
        else if (busy_reg && link[0].gflag)
        begin
            res_valid_next        = 1'b1;
            res_next.popped_value = link[0].gword;
            res_next.status       = ST_DONE;
            res_next.item_count   = cnt_ext[DQ_CNT_W-1:0];
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_reg;

    // occupied cells always match the count
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == int'(count_reg))
        else $error("cell occupancy does not match count");

    // at most one word walks the gather chain
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(gflag_vec))
        else $error("more than one gather flag");

    // a back pop in progress always has its word on the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot(gflag_vec))
        else $error("back pop lost its word");

    // empty rejection is only ever shown while the count is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == ST_EMPTY) |-> (count_reg == '0))
        else $error("empty status with stored items");

endmodule

`default_nettype wire
